@@ src/egcd_pkg.sv @@
// Package for the extended gcd block: operand and coefficient widths,
// and the packed types of the command and result beats. No dependencies.
`timescale 1ns / 1ps

package egcd_pkg;

    localparam int VALUE_BITS = 31;
    localparam int COEF_BITS  = VALUE_BITS + 1;
    localparam int CNT_W      = $clog2(VALUE_BITS);

    typedef struct packed {
        logic [VALUE_BITS-1:0] first_value;
        logic [VALUE_BITS-1:0] second_value;
    } t_in;

    typedef struct packed {
        logic                        status;
        logic [VALUE_BITS-1:0]       divisor_result;
        logic signed [COEF_BITS-1:0] first_coefficient;
        logic signed [COEF_BITS-1:0] second_coefficient;
    } t_out;

    typedef struct packed {
        logic [VALUE_BITS-1:0] rem;
        logic                  qbit;
        logic [COEF_BITS-1:0]  acc_x;
        logic [COEF_BITS-1:0]  acc_y;
    } t_step;

endpackage

@@ src/extended_gcd_bezout.sv @@
// Top level of the extended gcd block: sequencer, operand and coefficient
// registers and the result register. Depends on egcd_pkg and egcd_step.
//
// Usage. A command beat carrying two unsigned 31-bit operands is taken on a
// rising edge where start is high and busy is low. The block returns one
// result beat: gcd, Bezout coefficients s and t (32-bit two's complement,
// a*s + b*t = gcd) and a status bit that is set when both operands are zero.
// The result is shown on o_result for exactly one cycle with o_valid high;
// the receiver cannot stall it, so it must take it in that cycle.
// When the second operand is zero the result appears in the cycle after the
// command and busy stays low. Otherwise the block runs quotient rounds: each
// round passes the shared one-bit divide and multiply-accumulate unit over
// every dividend bit, then makes an update step, and the result appears in
// the cycle after the last round; a zero first operand costs a single round.
// Up to about 46 rounds occur for 31-bit operands. Busy stays high during
// the rounds, only one item is in work, and the next command may be taken in
// the cycle that shows the result.
// A synchronous reset returns the sequencer to idle and drops o_valid.
`timescale 1ns / 1ps

module extended_gcd_bezout (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  egcd_pkg::t_in  i_data,
    output logic           o_valid,
    output egcd_pkg::t_out o_result
);
    import egcd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [VALUE_BITS-1:0] r_b, n_b, r_rem, n_rem, r_dvd, n_dvd;
    logic [COEF_BITS-1:0]  r_x1, n_x1, r_x2, n_x2, r_y1, n_y1, r_y2, n_y2;
    logic [COEF_BITS-1:0]  r_accx, n_accx, r_accy, n_accy;
    logic                  r_valid, n_valid;
    t_out                  r_out, n_out;
    t_step                 step;

    egcd_step u_step (
        .i_rem     (r_rem),
        .i_dvd_bit (r_dvd[VALUE_BITS-1]),
        .i_divisor (r_b),
        .i_acc_x   (r_accx),
        .i_acc_y   (r_accy),
        .i_x2      (r_x2),
        .i_y2      (r_y2),
        .o_step    (step)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_b     = r_b;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_x1    = r_x1;
        n_x2    = r_x2;
        n_y1    = r_y1;
        n_y2    = r_y2;
        n_accx  = r_accx;
        n_accy  = r_accy;
        n_valid = 1'b0;
        n_out   = r_out;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_data.first_value == '0 && i_data.second_value == '0) begin
                        n_valid = 1'b1;
                        n_out   = '{1'b1, '0, '0, '0};
                    end else if (i_data.second_value == '0) begin
                        n_valid = 1'b1;
                        n_out   = '{1'b0, i_data.first_value, COEF_BITS'(1), '0};
                    end else begin
                        n_b     = i_data.second_value;
                        n_dvd   = i_data.first_value;
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_accx  = '0;
                        n_accy  = '0;
                        n_x1    = COEF_BITS'(1);
                        n_x2    = '0;
                        n_y1    = '0;
                        n_y2    = COEF_BITS'(1);
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem  = step.rem;
                n_dvd  = {r_dvd[VALUE_BITS-2:0], 1'b0};
                n_accx = step.acc_x;
                n_accy = step.acc_y;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_b  = r_rem;
                n_x1 = r_x2;
                n_x2 = r_x1 - r_accx;
                n_y1 = r_y2;
                n_y2 = r_y1 - r_accy;
                if (r_rem == '0) begin
                    n_valid = 1'b1;
                    n_out   = '{1'b0, r_b, r_x2, r_y2};
                    n_state = S_IDLE;
                end else begin
                    n_dvd   = r_b;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_accx  = '0;
                    n_accy  = '0;
                    n_state = S_DIV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_cnt  <= n_cnt;
        r_b    <= n_b;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_x1   <= n_x1;
        r_x2   <= n_x2;
        r_y1   <= n_y1;
        r_y2   <= n_y2;
        r_accx <= n_accx;
        r_accy <= n_accy;
        r_out  <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("Result beat shown while the sequencer is busy.");

    a_fell_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("Sequencer finished without a result beat.");

    a_zero_args: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_data.first_value == '0 && i_data.second_value == '0)
        |=> (o_valid && o_result.status))
        else $error("Both-zero command did not report the error status.");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.status) |-> (o_result.divisor_result != '0))
        else $error("Successful result carries a zero gcd.");

endmodule

@@ src/egcd_step.sv @@
// Shared arithmetic unit: one restoring division step that also folds the
// quotient bit into the products q*x2 and q*y2. Depends on egcd_pkg.
`timescale 1ns / 1ps

module egcd_step (
    input  logic [egcd_pkg::VALUE_BITS-1:0] i_rem,
    input  logic                            i_dvd_bit,
    input  logic [egcd_pkg::VALUE_BITS-1:0] i_divisor,
    input  logic [egcd_pkg::COEF_BITS-1:0]  i_acc_x,
    input  logic [egcd_pkg::COEF_BITS-1:0]  i_acc_y,
    input  logic [egcd_pkg::COEF_BITS-1:0]  i_x2,
    input  logic [egcd_pkg::COEF_BITS-1:0]  i_y2,
    output egcd_pkg::t_step                 o_step
);
    import egcd_pkg::*;

    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS+1:0] trial;
    logic                  fits;

    always_comb begin
        shifted = {i_rem, i_dvd_bit};
        trial   = {1'b0, shifted} - {2'b00, i_divisor};
        fits    = ~trial[VALUE_BITS+1];
        o_step.qbit  = fits;
        o_step.rem   = fits ? trial[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
        o_step.acc_x = {i_acc_x[COEF_BITS-2:0], 1'b0} + (fits ? i_x2 : '0);
        o_step.acc_y = {i_acc_y[COEF_BITS-2:0], 1'b0} + (fits ? i_y2 : '0);
    end

endmodule
